### hw/rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// shared types and constants of the set-associative fifo cache
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int DEF_WAYS = 8;
    localparam int DEF_SETS = 64;

    localparam int KEY_W  = 64;
    localparam int HASH_W = 32;
    localparam int PAY_W  = 32;
    localparam int KIND_W = 2;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALIDATE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] key_hash;
        logic [PAY_W-1:0]  payload_in;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [PAY_W-1:0] payload_out;
        logic             evicted;
    } rsp_t;

    // outcome of one row update
    typedef struct packed {
        logic             found;
        logic             evicted;
        logic [PAY_W-1:0] payload_out;
        logic             mem_we;
    } upd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_EXEC
    } state_t;

endpackage

### hw/rtl/sac_row_mem.sv
// ----------------------------------------------------------------------------
// sac_row_mem
// one row per set: synchronous write, registered read
// ----------------------------------------------------------------------------
module sac_row_mem #(
    parameter int WIDTH = sac_pkg::DEF_WAYS * (1 + sac_pkg::KEY_W + sac_pkg::PAY_W),
    parameter int DEPTH = sac_pkg::DEF_SETS,
    parameter int AW    = $clog2(sac_pkg::DEF_SETS)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/sac_set_index.sv
// ----------------------------------------------------------------------------
// sac_set_index
// set index = hash mod SETS; mask for a power of two, else reciprocal multiply
// ----------------------------------------------------------------------------
module sac_set_index #(
    parameter int SETS  = sac_pkg::DEF_SETS,
    parameter int SET_W = 6
) (
    input  logic                      clk,
    input  logic                      div_en,
    input  logic [sac_pkg::HASH_W-1:0] hash,
    output logic [SET_W-1:0]          set_idx
);

    import sac_pkg::*;

    localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

    generate
        if (POW2)
        begin : g_mask
            assign set_idx = SET_W'(hash % SETS);
        end
        else
        begin : g_recip
            localparam int SHIFT = HASH_W + SET_W;
            localparam int PW    = 2 * HASH_W + 1;
            localparam int QW    = HASH_W + SET_W + 1;
            localparam logic [HASH_W:0] RECIP = (HASH_W + 1)'((64'd1 << SHIFT) / SETS);

            logic [PW-1:0]     q_prod;
            logic [HASH_W-1:0] q_reg;
            logic [QW-1:0]     qs;
            logic [QW-1:0]     r_full;
            logic [SET_W:0]    r_low;

            // quotient estimate is exact or one low
            assign q_prod = PW'(hash) * PW'(RECIP);

            always_ff @(posedge clk)
            begin
                if (div_en)
                begin
                    q_reg <= HASH_W'(q_prod >> SHIFT);
                end
            end

            assign qs     = QW'(q_reg) * QW'(SETS);
            assign r_full = QW'(hash) - qs;
            assign r_low  = r_full[SET_W:0];
            assign set_idx = (r_low >= (SET_W + 1)'(SETS)) ?
                             SET_W'(r_low - (SET_W + 1)'(SETS)) : SET_W'(r_low);
        end
    endgenerate

endmodule

### hw/rtl/sac_row_update.sv
// ----------------------------------------------------------------------------
// sac_row_update
// parallel way compare and new row contents for one operation
// ----------------------------------------------------------------------------
module sac_row_update #(
    parameter int WAYS = sac_pkg::DEF_WAYS
) (
    input  logic [sac_pkg::KIND_W-1:0]     kind,
    input  logic [sac_pkg::KEY_W-1:0]      key,
    input  logic [sac_pkg::PAY_W-1:0]      payload_in,
    input  logic [WAYS-1:0]                valid_row,
    input  logic [WAYS*sac_pkg::KEY_W-1:0] key_row,
    input  logic [WAYS*sac_pkg::PAY_W-1:0] pay_row,
    output logic [WAYS-1:0]                valid_next,
    output logic [WAYS*sac_pkg::KEY_W-1:0] key_next,
    output logic [WAYS*sac_pkg::PAY_W-1:0] pay_next,
    output sac_pkg::upd_t                  upd
);

    import sac_pkg::*;

    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  first;
    logic [WAYS-1:0]  inv;
    logic [WAYS-1:0]  empty_sel;
    logic             hit;
    logic             has_empty;
    logic [PAY_W-1:0] hit_pay;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = valid_row[w] && (key_row[w*KEY_W +: KEY_W] == key);
        end
    end

    // lowest matching way, highest empty way
    assign first     = match & (~match + WAYS'(1));
    assign inv       = ~valid_row;
    assign hit       = |match;
    assign has_empty = |inv;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            empty_sel[w] = inv[w] && ((inv >> (w + 1)) == '0);
        end
    end

    always_comb
    begin
        hit_pay = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (first[w])
            begin
                hit_pay = hit_pay | pay_row[w*PAY_W +: PAY_W];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_row;
        key_next   = key_row;
        pay_next   = pay_row;
        upd        = '0;
        unique case (kind) inside
            KIND_INSERT:
            begin
                upd.mem_we = 1'b1;
                if (hit)
                begin
                    upd.found = 1'b1;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (first[w])
                        begin
                            pay_next[w*PAY_W +: PAY_W] = payload_in;
                        end
                    end
                end
                else if (has_empty)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (empty_sel[w])
                        begin
                            valid_next[w]              = 1'b1;
                            key_next[w*KEY_W +: KEY_W] = key;
                            pay_next[w*PAY_W +: PAY_W] = payload_in;
                        end
                    end
                end
                else
                begin
                    // full set: drop way 0, shift down, append at the top
                    upd.evicted = 1'b1;
                    for (int w = 0; w < WAYS - 1; w++)
                    begin
                        key_next[w*KEY_W +: KEY_W] = key_row[(w+1)*KEY_W +: KEY_W];
                        pay_next[w*PAY_W +: PAY_W] = pay_row[(w+1)*PAY_W +: PAY_W];
                    end
                    key_next[(WAYS-1)*KEY_W +: KEY_W] = key;
                    pay_next[(WAYS-1)*PAY_W +: PAY_W] = payload_in;
                    valid_next                        = '1;
                end
            end
            KIND_LOAD,
            KIND_INVALIDATE:
            begin
                if (hit)
                begin
                    upd.found  = 1'b1;
                    upd.mem_we = 1'b1;
                    valid_next = valid_row & ~first;
                    if (kind == KIND_LOAD)
                    begin
                        upd.payload_out = hit_pay;
                    end
                end
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/set_assoc_fifo_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_fifo_cache
// set-associative key/payload store with fifo replacement per set
// ----------------------------------------------------------------------------
//
//  channel | signals                     | direction | moves
//  --------+-----------------------------+-----------+---------------------------
//  req     | req_valid, req_ready, req   | in        | operation, key, hash, payload
//  rsp     | rsp_valid, rsp_ready, rsp   | out       | found, payload_out, evicted
//
//  one transaction at a time; when SETS is not a power of two the request
//  first passes the DIV_MUL and DIV_FIX states of the reciprocal-multiply
//  modulo; the row memory read and the read-modify-write of that row follow
//  valid bits share the row with keys and payloads; after rst_n a clearing
//  pass writes every row to zero, one row a cycle, so req_ready stays low
//  until the last row is written
//  the response register lets a new request enter while a response waits;
//  the update of a row holds until the response register is free
//
module set_assoc_fifo_cache #(
    parameter int WAYS = sac_pkg::DEF_WAYS,
    parameter int SETS = sac_pkg::DEF_SETS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sac_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sac_pkg::rsp_t rsp
);

    import sac_pkg::*;

    localparam int  SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int  DATA_W = WAYS * (KEY_W + PAY_W);
    localparam int  ROW_W = WAYS + DATA_W;
    localparam bit  POW2  = ((SETS & (SETS - 1)) == 0);

    state_t state_reg;
    state_t state_next;

    // sequencer strobes
    logic rd_en;
    logic div_en;
    logic commit;
    logic clr_we;

    // clearing pass row counter
    logic [SET_W-1:0] clr_reg;
    logic [SET_W-1:0] clr_next;

    req_t             item_reg;
    logic [SET_W-1:0] set_reg;
    logic [SET_W-1:0] set_idx;
    logic [HASH_W-1:0] hash_sel;

    logic [ROW_W-1:0]       rd_row;
    logic [ROW_W-1:0]       wr_row;
    logic                   mem_we;
    logic [SET_W-1:0]       mem_waddr;
    logic [ROW_W-1:0]       mem_wdata;
    logic [WAYS-1:0]        valid_next;
    logic [WAYS*KEY_W-1:0]  key_next;
    logic [WAYS*PAY_W-1:0]  pay_next;
    upd_t                   upd;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rd_en      = 1'b0;
        div_en     = 1'b0;
        commit     = 1'b0;
        clr_we     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // one row per cycle, no requests until the last row is done
                clr_we = 1'b1;
                if (clr_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    // power-of-two set count reads the row right away
                    rd_en      = POW2;
                    state_next = POW2 ? ST_EXEC : ST_DIV_MUL;
                end
            end
            ST_DIV_MUL:
            begin
                div_en     = 1'b1;
                state_next = ST_DIV_FIX;
            end
            ST_DIV_FIX:
            begin
                rd_en      = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign clr_next = clr_reg + SET_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clr_we)
        begin
            clr_reg <= clr_next;
        end
    end

    // ------------------------------------------------------------------
    // request capture and set index
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
    end

    // the idle read uses the hash straight from the port
    assign hash_sel = (state_reg == ST_IDLE) ? req.key_hash : item_reg.key_hash;

    sac_set_index #(
        .SETS  (SETS),
        .SET_W (SET_W)
    ) u_set_index (
        .clk     (clk),
        .div_en  (div_en),
        .hash    (hash_sel),
        .set_idx (set_idx)
    );

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            set_reg <= set_idx;
        end
    end

    // ------------------------------------------------------------------
    // row memory: valid bits on top, then keys, then payloads
    // ------------------------------------------------------------------
    assign wr_row = {valid_next, key_next, pay_next};

    // the clearing pass owns the write port right after reset
    assign mem_we    = clr_we || (commit && upd.mem_we);
    assign mem_waddr = clr_we ? clr_reg : set_reg;
    assign mem_wdata = clr_we ? '0 : wr_row;

    sac_row_mem #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .AW    (SET_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (set_idx),
        .rd_data (rd_row),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    // ------------------------------------------------------------------
    // compare and update of the row that was read
    // ------------------------------------------------------------------
    sac_row_update #(
        .WAYS (WAYS)
    ) u_row_update (
        .kind       (item_reg.kind),
        .key        (item_reg.key),
        .payload_in (item_reg.payload_in),
        .valid_row  (rd_row[ROW_W-1 -: WAYS]),
        .key_row    (rd_row[DATA_W-1 -: WAYS*KEY_W]),
        .pay_row    (rd_row[WAYS*PAY_W-1:0]),
        .valid_next (valid_next),
        .key_next   (key_next),
        .pay_next   (pay_next),
        .upd        (upd)
    );

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg.found       <= upd.found;
            rsp_reg.payload_out <= upd.payload_out;
            rsp_reg.evicted     <= upd.evicted;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
